### rtl/spsc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the pair support counter.
`timescale 1ns / 1ps

package spsc_pkg;

	// Fixed field widths of the item and result ports.
	localparam int ITEM_W = 6;
	localparam int TID_W  = 32;
	localparam int SUP_W  = 32;
	localparam int STAT_W = 2;

	// Defaults for the top-level parameters.
	localparam int DEF_NUM_ITEMS  = 64;
	localparam int DEF_MAX_PAIRS  = 256;
	localparam int DEF_COUNT_BITS = 32;

	// Request codes.
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_STORED   = 2'd0;
	localparam logic [STAT_W-1:0] ST_COUNTED  = 2'd1;
	localparam logic [STAT_W-1:0] ST_QUERY    = 2'd2;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

	// Which counter a bump addresses.
	localparam logic [1:0] BSEL_AB  = 2'd0;
	localparam logic [1:0] BSEL_BA  = 2'd1;
	localparam logic [1:0] BSEL_SET = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       clr_step;
		logic       ld_out;
		logic       q_out;
		logic       cnt_out;
		logic       grp_sel_j;
		logic       gi_first;
		logic       gi_inc;
		logic       gj_from_gi;
		logic       gj_inc;
		logic       lat_a;
		logic       lat_b;
		logic       mrg_init;
		logic       mrg_step;
		logic [1:0] bump_sel;
		logic       bump_wr;
	} spsc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic ld_count;
		logic out_valid;
		logic f_ab;
		logic f_ba;
		logic f_set;
		logic tid_eq;
		logic mrg_more;
		logic gj_more;
		logic gi_more;
	} spsc_stat_t;

endpackage

### rtl/sequence_pair_support_counter.sv
// Top level of the sequence pair support counter: controller and datapath.
//
//  channel | signals                                         | accepted when
//  --------+-------------------------------------------------+------------------------
//  in      | req_type item_index trans_id last_of_customer    | in_valid && in_ready
//          | query_first query_second                        |
//  out     | status seq_count set_count seq_frequent          | out_valid && out_ready
//          | set_frequent                                    |
//  cfg     | cfg_data (min_support)                          | cfg_we
//
// A load that does not end a customer is answered from idle; a query first passes S_QRY
// (counter memory read). A customer's last pair, unless it overflowed, starts a walk over
// all group pairs (i <= j): S_GJ, S_GJL, S_EVAL and S_NEXT per pair, S_GI and S_GIL per
// first group, a read and a write per counter bump, a read and a compare per merge step
// over pair ids, then S_DONE. After reset, with in_ready low, the counter memories are
// cleared an address a cycle. A held result blocks new items only while out_ready is low.
`timescale 1ns / 1ps

module sequence_pair_support_counter #(
	parameter int NUM_ITEMS  = spsc_pkg::DEF_NUM_ITEMS,
	parameter int MAX_PAIRS  = spsc_pkg::DEF_MAX_PAIRS,
	parameter int COUNT_BITS = spsc_pkg::DEF_COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [spsc_pkg::ITEM_W-1:0] item_index,
	input  logic [spsc_pkg::TID_W-1:0]  trans_id,
	input  logic                        last_of_customer,
	input  logic [spsc_pkg::ITEM_W-1:0] query_first,
	input  logic [spsc_pkg::ITEM_W-1:0] query_second,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [spsc_pkg::STAT_W-1:0] status,
	output logic [COUNT_BITS-1:0]       seq_count,
	output logic [COUNT_BITS-1:0]       set_count,
	output logic                        seq_frequent,
	output logic                        set_frequent,
	input  logic                        cfg_we,
	input  logic [spsc_pkg::SUP_W-1:0]  cfg_data
);

	spsc_pkg::spsc_cmd_t  cmd;
	spsc_pkg::spsc_stat_t stat;
	logic                 accept;

	assign accept = in_valid && in_ready;

	// Sequencer.
	spsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.out_ready (out_ready),
		.stat      (stat),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	// Storage, compare and counting datapath.
	spsc_dp #(
		.NUM_ITEMS  (NUM_ITEMS),
		.MAX_PAIRS  (MAX_PAIRS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.req_type         (req_type),
		.item_index       (item_index),
		.trans_id         (trans_id),
		.last_of_customer (last_of_customer),
		.query_first      (query_first),
		.query_second     (query_second),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.out_ready        (out_ready),
		.cmd              (cmd),
		.stat             (stat),
		.out_valid        (out_valid),
		.status           (status),
		.seq_count        (seq_count),
		.set_count        (set_count),
		.seq_frequent     (seq_frequent),
		.set_frequent     (set_frequent)
	);

endmodule

### rtl/spsc_ctrl.sv
// Controller state machine for the pair support counter.
`timescale 1ns / 1ps

module spsc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  req_type,
	input  logic                  out_ready,
	input  spsc_pkg::spsc_stat_t  stat,
	output logic                  in_ready,
	output spsc_pkg::spsc_cmd_t   cmd
);

	typedef enum logic [17:0] {
		S_CLR     = 18'h00001,
		S_IDLE    = 18'h00002,
		S_QRY     = 18'h00004,
		S_GI      = 18'h00008,
		S_GIL     = 18'h00010,
		S_GJ      = 18'h00020,
		S_GJL     = 18'h00040,
		S_EVAL    = 18'h00080,
		S_AB_RD   = 18'h00100,
		S_AB_WR   = 18'h00200,
		S_BA_RD   = 18'h00400,
		S_BA_WR   = 18'h00800,
		S_MRG_RD  = 18'h01000,
		S_MRG_CMP = 18'h02000,
		S_SET_RD  = 18'h04000,
		S_SET_WR  = 18'h08000,
		S_NEXT    = 18'h10000,
		S_DONE    = 18'h20000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// Items enter only in idle, and only when the result slot is free or draining.
	assign in_ready = (state_q == S_IDLE) && (!stat.out_valid || out_ready);
	assign accept   = in_valid && in_ready;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req_type == spsc_pkg::REQ_QUERY) begin
						state_d = S_QRY;
					end else if (stat.ld_count) begin
						cmd.gi_first = 1'b1;
						state_d      = S_GI;
					end else begin
						cmd.ld_out = 1'b1;
					end
				end
			end
			S_QRY: begin
				cmd.q_out = 1'b1;
				state_d   = S_IDLE;
			end
			S_GI: begin
				state_d = S_GIL;
			end
			S_GIL: begin
				cmd.lat_a      = 1'b1;
				cmd.gj_from_gi = 1'b1;
				state_d        = S_GJ;
			end
			S_GJ: begin
				cmd.grp_sel_j = 1'b1;
				state_d       = S_GJL;
			end
			S_GJL: begin
				cmd.lat_b = 1'b1;
				state_d   = S_EVAL;
			end
			S_EVAL: begin
				cmd.mrg_init = 1'b1;
				if (stat.f_ab) begin
					state_d = S_AB_RD;
				end else if (stat.f_ba) begin
					state_d = S_BA_RD;
				end else if (stat.f_set) begin
					state_d = S_MRG_RD;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_AB_RD: begin
				cmd.bump_sel = spsc_pkg::BSEL_AB;
				state_d      = S_AB_WR;
			end
			S_AB_WR: begin
				cmd.bump_sel = spsc_pkg::BSEL_AB;
				cmd.bump_wr  = 1'b1;
				if (stat.f_ba) begin
					state_d = S_BA_RD;
				end else if (stat.f_set) begin
					state_d = S_MRG_RD;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_BA_RD: begin
				cmd.bump_sel = spsc_pkg::BSEL_BA;
				state_d      = S_BA_WR;
			end
			S_BA_WR: begin
				cmd.bump_sel = spsc_pkg::BSEL_BA;
				cmd.bump_wr  = 1'b1;
				state_d      = stat.f_set ? S_MRG_RD : S_NEXT;
			end
			S_MRG_RD: begin
				state_d = S_MRG_CMP;
			end
			S_MRG_CMP: begin
				if (stat.tid_eq) begin
					state_d = S_SET_RD;
				end else begin
					cmd.mrg_step = 1'b1;
					state_d      = stat.mrg_more ? S_MRG_RD : S_NEXT;
				end
			end
			S_SET_RD: begin
				cmd.bump_sel = spsc_pkg::BSEL_SET;
				state_d      = S_SET_WR;
			end
			S_SET_WR: begin
				cmd.bump_sel = spsc_pkg::BSEL_SET;
				cmd.bump_wr  = 1'b1;
				state_d      = S_NEXT;
			end
			S_NEXT: begin
				if (stat.gj_more) begin
					cmd.gj_inc = 1'b1;
					state_d    = S_GJ;
				end else if (stat.gi_more) begin
					cmd.gi_inc = 1'b1;
					state_d    = S_GI;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.cnt_out = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the counter clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/spsc_dp.sv
// Datapath of the pair support counter: pair and group buffers, counter memories, result register.
`timescale 1ns / 1ps

module spsc_dp #(
	parameter int NUM_ITEMS  = spsc_pkg::DEF_NUM_ITEMS,
	parameter int MAX_PAIRS  = spsc_pkg::DEF_MAX_PAIRS,
	parameter int COUNT_BITS = spsc_pkg::DEF_COUNT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              req_type,
	input  logic [spsc_pkg::ITEM_W-1:0]       item_index,
	input  logic [spsc_pkg::TID_W-1:0]        trans_id,
	input  logic                              last_of_customer,
	input  logic [spsc_pkg::ITEM_W-1:0]       query_first,
	input  logic [spsc_pkg::ITEM_W-1:0]       query_second,
	input  logic                              cfg_we,
	input  logic [spsc_pkg::SUP_W-1:0]        cfg_data,
	input  logic                              out_ready,
	input  spsc_pkg::spsc_cmd_t               cmd,
	output spsc_pkg::spsc_stat_t              stat,
	output logic                              out_valid,
	output logic [spsc_pkg::STAT_W-1:0]       status,
	output logic [COUNT_BITS-1:0]             seq_count,
	output logic [COUNT_BITS-1:0]             set_count,
	output logic                              seq_frequent,
	output logic                              set_frequent
);

	localparam int PTR_W     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int FILL_W    = $clog2(MAX_PAIRS + 1);
	localparam int CNT_DEPTH = NUM_ITEMS * NUM_ITEMS;
	localparam int CA_W      = $clog2(CNT_DEPTH);
	localparam int IW        = spsc_pkg::ITEM_W;
	localparam int TW        = spsc_pkg::TID_W;
	localparam int SW        = spsc_pkg::SUP_W;

	// Memories.
	logic [TW-1:0]         tid_mem   [MAX_PAIRS];
	logic [IW-1:0]         g_item_mem[MAX_PAIRS];
	logic [PTR_W-1:0]      g_start_mem[MAX_PAIRS];
	logic [FILL_W-1:0]     g_end_mem [MAX_PAIRS];
	logic [TW-1:0]         g_first_mem[MAX_PAIRS];
	logic [TW-1:0]         g_last_mem[MAX_PAIRS];
	logic [COUNT_BITS-1:0] seq_mem   [CNT_DEPTH];
	logic [COUNT_BITS-1:0] set_mem   [CNT_DEPTH];

	// Control registers.
	logic [FILL_W-1:0] fill_q, ngroups_q, total_q, gi_q, gj_q;
	logic              ovf_q;
	logic [CA_W-1:0]   clr_addr_q;
	logic [SW-1:0]     min_q;
	logic              out_valid_q;

	// Payload registers.
	logic [IW-1:0]     prev_item_q, qa_q, qb_q;
	logic [PTR_W-1:0]  cur_start_q;
	logic [TW-1:0]     cur_first_q;
	logic              q_inr_q;
	logic [IW-1:0]     g_item_rd_q, a_item_q, b_item_q;
	logic [PTR_W-1:0]  g_start_rd_q, a_start_q, b_start_q;
	logic [FILL_W-1:0] g_end_rd_q, a_end_q, b_end_q;
	logic [TW-1:0]     g_first_rd_q, g_last_rd_q, a_first_q, a_last_q, b_first_q, b_last_q;
	logic [FILL_W-1:0] k_q, l_q;
	logic [TW-1:0]     tid_k_q, tid_l_q;
	logic [COUNT_BITS-1:0] seq_rd_q, set_rd_q;
	logic [spsc_pkg::STAT_W-1:0] status_q;
	logic [COUNT_BITS-1:0] seq_out_q, set_out_q;
	logic              seq_f_q, set_f_q;

	// Load-side decode.
	logic              is_load, full, ovf_eff, new_grp;
	logic [FILL_W-1:0] ngroups_next;
	logic [PTR_W-1:0]  gidx, start_w;
	logic [TW-1:0]     first_w;
	logic [spsc_pkg::STAT_W-1:0] ld_stat;

	assign is_load      = accept && (req_type == spsc_pkg::REQ_LOAD);
	assign full         = (fill_q == FILL_W'(MAX_PAIRS));
	assign ovf_eff      = ovf_q || full;
	assign new_grp      = (fill_q == '0) || (item_index != prev_item_q);
	assign ngroups_next = full ? ngroups_q : (ngroups_q + FILL_W'(new_grp));
	assign gidx         = new_grp ? ngroups_q[PTR_W-1:0] : PTR_W'(ngroups_q - FILL_W'(1));
	assign start_w      = new_grp ? fill_q[PTR_W-1:0] : cur_start_q;
	assign first_w      = new_grp ? trans_id : cur_first_q;
	assign ld_stat      = ovf_eff ? spsc_pkg::ST_OVERFLOW
	                    : (last_of_customer ? spsc_pkg::ST_COUNTED : spsc_pkg::ST_STORED);

	// Pair and group stores, written on each stored pair.
	always_ff @(posedge clk) begin
		if (is_load && !full) begin
			tid_mem[fill_q[PTR_W-1:0]] <= trans_id;
			g_item_mem[gidx]           <= item_index;
			g_start_mem[gidx]          <= start_w;
			g_end_mem[gidx]            <= fill_q + FILL_W'(1);
			g_first_mem[gidx]          <= first_w;
			g_last_mem[gidx]           <= trans_id;
		end
	end

	// Group and pair reads, registered every cycle.
	always_ff @(posedge clk) begin
		logic [PTR_W-1:0] ga;
		ga = cmd.grp_sel_j ? gj_q[PTR_W-1:0] : gi_q[PTR_W-1:0];
		g_item_rd_q  <= g_item_mem[ga];
		g_start_rd_q <= g_start_mem[ga];
		g_end_rd_q   <= g_end_mem[ga];
		g_first_rd_q <= g_first_mem[ga];
		g_last_rd_q  <= g_last_mem[ga];
		tid_k_q      <= tid_mem[k_q[PTR_W-1:0]];
		tid_l_q      <= tid_mem[l_q[PTR_W-1:0]];
	end

	// Load bookkeeping and group walk indices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			ngroups_q  <= '0;
			total_q    <= '0;
			ovf_q      <= 1'b0;
			gi_q       <= '0;
			gj_q       <= '0;
			clr_addr_q <= '0;
			min_q      <= SW'(1);
		end else begin
			if (cfg_we) begin
				min_q <= cfg_data;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + CA_W'(1);
			end
			if (is_load) begin
				if (last_of_customer) begin
					fill_q    <= '0;
					ngroups_q <= '0;
					ovf_q     <= 1'b0;
					total_q   <= ngroups_next;
				end else begin
					fill_q    <= full ? fill_q : (fill_q + FILL_W'(1));
					ngroups_q <= ngroups_next;
					ovf_q     <= ovf_eff;
				end
			end
			if (cmd.gi_first) begin
				gi_q <= '0;
			end else if (cmd.gi_inc) begin
				gi_q <= gi_q + FILL_W'(1);
			end
			if (cmd.gj_from_gi) begin
				gj_q <= gi_q;
			end else if (cmd.gj_inc) begin
				gj_q <= gj_q + FILL_W'(1);
			end
		end
	end

	// Current group tracking, group records under evaluation and merge pointers.
	always_ff @(posedge clk) begin
		if (is_load && !full) begin
			prev_item_q <= item_index;
			cur_start_q <= start_w;
			cur_first_q <= first_w;
		end
		if (accept && (req_type == spsc_pkg::REQ_QUERY)) begin
			qa_q    <= query_first;
			qb_q    <= query_second;
			q_inr_q <= (int'(query_first) < NUM_ITEMS) && (int'(query_second) < NUM_ITEMS);
		end
		if (cmd.lat_a) begin
			a_item_q  <= g_item_rd_q;
			a_start_q <= g_start_rd_q;
			a_end_q   <= g_end_rd_q;
			a_first_q <= g_first_rd_q;
			a_last_q  <= g_last_rd_q;
		end
		if (cmd.lat_b) begin
			b_item_q  <= g_item_rd_q;
			b_start_q <= g_start_rd_q;
			b_end_q   <= g_end_rd_q;
			b_first_q <= g_first_rd_q;
			b_last_q  <= g_last_rd_q;
		end
		if (cmd.mrg_init) begin
			k_q <= FILL_W'(a_start_q);
			l_q <= FILL_W'(b_start_q);
		end else if (cmd.mrg_step) begin
			if (tid_k_q > tid_l_q) begin
				l_q <= l_q + FILL_W'(1);
			end else begin
				k_q <= k_q + FILL_W'(1);
			end
		end
	end

	// Pair evaluation flags from the two latched group records.
	logic both_inr, j_after_i;
	assign both_inr  = (int'(a_item_q) < NUM_ITEMS) && (int'(b_item_q) < NUM_ITEMS);
	assign j_after_i = (gj_q != gi_q);

	// Counter addresses.
	logic [CA_W-1:0] addr_ab, addr_ba, addr_q, bump_addr, rd_addr, wr_addr;
	assign addr_ab = CA_W'(int'(a_item_q) * NUM_ITEMS + int'(b_item_q));
	assign addr_ba = CA_W'(int'(b_item_q) * NUM_ITEMS + int'(a_item_q));
	assign addr_q  = CA_W'(int'(query_first) * NUM_ITEMS + int'(query_second));

	always_comb begin
		case (cmd.bump_sel)
			spsc_pkg::BSEL_BA: bump_addr = addr_ba;
			default:           bump_addr = addr_ab;
		endcase
	end

	assign rd_addr = (accept && (req_type == spsc_pkg::REQ_QUERY)) ? addr_q : bump_addr;
	assign wr_addr = cmd.clr_step ? clr_addr_q : bump_addr;

	// Saturating increments of the values just read.
	logic [COUNT_BITS-1:0] seq_inc, set_inc;
	assign seq_inc = (&seq_rd_q) ? seq_rd_q : (seq_rd_q + COUNT_BITS'(1));
	assign set_inc = (&set_rd_q) ? set_rd_q : (set_rd_q + COUNT_BITS'(1));

	logic seq_we, set_we;
	assign seq_we = cmd.clr_step || (cmd.bump_wr && (cmd.bump_sel != spsc_pkg::BSEL_SET));
	assign set_we = cmd.clr_step || (cmd.bump_wr && (cmd.bump_sel == spsc_pkg::BSEL_SET));

	// Counter memories: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (seq_we) begin
			seq_mem[wr_addr] <= cmd.clr_step ? '0 : seq_inc;
		end
		seq_rd_q <= seq_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (set_we) begin
			set_mem[wr_addr] <= cmd.clr_step ? '0 : set_inc;
		end
		set_rd_q <= set_mem[rd_addr];
	end

	// Query answer values.
	logic [COUNT_BITS-1:0] q_seq, q_set;
	assign q_seq = q_inr_q ? seq_rd_q : '0;
	assign q_set = (q_inr_q && (qa_q < qb_q)) ? set_rd_q : '0;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out || cmd.q_out || cmd.cnt_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_out) begin
			status_q  <= spsc_pkg::ST_QUERY;
			seq_out_q <= q_seq;
			set_out_q <= q_set;
			seq_f_q   <= (SW'(q_seq) >= min_q);
			set_f_q   <= (SW'(q_set) >= min_q);
		end else if (cmd.ld_out || cmd.cnt_out) begin
			status_q  <= cmd.cnt_out ? spsc_pkg::ST_COUNTED : ld_stat;
			seq_out_q <= '0;
			set_out_q <= '0;
			seq_f_q   <= 1'b0;
			set_f_q   <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign seq_count    = seq_out_q;
	assign set_count    = set_out_q;
	assign seq_frequent = seq_f_q;
	assign set_frequent = set_f_q;

	// Status toward the controller.
	always_comb begin
		stat           = '0;
		stat.clr_done  = (clr_addr_q == CA_W'(CNT_DEPTH - 1));
		stat.ld_count  = last_of_customer && !ovf_eff;
		stat.out_valid = out_valid_q;
		stat.f_ab      = both_inr && (a_first_q < b_last_q);
		stat.f_ba      = both_inr && j_after_i && (b_first_q < a_last_q);
		stat.f_set     = both_inr && j_after_i && (a_item_q < b_item_q);
		stat.tid_eq    = (tid_k_q == tid_l_q);
		if (tid_k_q > tid_l_q) begin
			stat.mrg_more = (l_q + FILL_W'(1)) < b_end_q;
		end else begin
			stat.mrg_more = (k_q + FILL_W'(1)) < a_end_q;
		end
		stat.gj_more   = (gj_q + FILL_W'(1)) < total_q;
		stat.gi_more   = (gi_q + FILL_W'(1)) < total_q;
	end

endmodule

### rtl/spsc_checker.sv
// Port-level checker for the sequence pair support counter and its bind.
`timescale 1ns / 1ps

module spsc_checker #(
	parameter int COUNT_BITS = spsc_pkg::DEF_COUNT_BITS
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [spsc_pkg::STAT_W-1:0] status,
	input logic [COUNT_BITS-1:0]       seq_count,
	input logic [COUNT_BITS-1:0]       set_count,
	input logic                        seq_frequent,
	input logic                        set_frequent
);

	// A stalled result holds its status and counts.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(seq_count)
		&& $stable(set_count))
		else $error("result changed while stalled");

	// Only query answers carry counts or flags.
	a_nonquery_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != spsc_pkg::ST_QUERY) |->
		(seq_count == '0) && (set_count == '0) && !seq_frequent && !set_frequent)
		else $error("nonzero count on a non-query result");

	// No new item is taken while a result is stuck in the output slot.
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while the result slot is blocked");

	// A query answer with only the set flag raised has a set count no smaller than its sequence count.
	a_set_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == spsc_pkg::ST_QUERY) && set_frequent && !seq_frequent |->
		(set_count > seq_count) || (set_count == seq_count))
		else $error("set flag set with a smaller count than an unflagged count");

endmodule

bind sequence_pair_support_counter spsc_checker #(.COUNT_BITS(COUNT_BITS)) u_spsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.seq_count    (seq_count),
	.set_count    (set_count),
	.seq_frequent (seq_frequent),
	.set_frequent (set_frequent)
);
